@@ rtl/uxtd_pkg.sv @@
// shared types, constants and lookup functions for the unix time date feature pipeline
package uxtd_pkg;

  // input transfer payload
  typedef struct packed {
    logic signed [63:0] timestamp_seconds;
    logic               missing_in;
  } in_t;

  // output transfer payload
  typedef struct packed {
    logic [2:0] day_of_week;
    logic [3:0] month_number;
    logic [8:0] day_of_year;
    logic [2:0] quarter_number;
    logic       is_weekend;
    logic       missing_out;
  } out_t;

  // 86400 = 128 * 675: the power of two goes away as an arithmetic shift
  localparam int DayShift = 7;
  localparam int RemW     = 27;  // width of a value below ModM
  localparam int SumW     = 45;  // width of the partial-product sum
  localparam int QuoW     = 19;  // width of the estimated quotient
  localparam int RedW     = 29;  // width of the partially reduced remainder
  localparam int DayW     = 18;  // width of a day within a 400-year era

  // ModM = 675 * 146097: shifted seconds modulo this give the day within an era
  localparam logic [63:0] ModM     = 64'd98615475;
  localparam logic [63:0] Pow32Mod = (64'd1 << 32) % ModM;
  localparam logic [63:0] Pow48Mod = (64'd1 << 48) % ModM;
  // the top chunk is biased by +256, this undoes 256 * 2^48 modulo ModM
  localparam logic [63:0] TopBias  = ModM - ((64'd1 << 56) % ModM);

  // quotient estimate for the sum: ((sum >> 20) * RecipM) >> 32
  localparam int          QuoPreShift  = 20;
  localparam int          QuoPostShift = 32;
  localparam logic [63:0] RecipM       = (64'd1 << 52) / ModM;

  // exact reciprocals, rounded up: floor(x / d) == (x * r) >> s over the operand range
  localparam int          DivSecShift  = 37;
  localparam logic [63:0] RecipSec     = ((64'd1 << 37) + 64'd674) / 64'd675;
  localparam int          Div7Shift    = 22;
  localparam logic [63:0] Recip7       = ((64'd1 << 22) + 64'd6) / 64'd7;
  localparam int          Div1460Shift = 29;
  localparam logic [63:0] Recip1460    = ((64'd1 << 29) + 64'd1459) / 64'd1460;
  localparam int          Div36524Shift = 34;
  localparam logic [63:0] Recip36524   = ((64'd1 << 34) + 64'd36523) / 64'd36524;
  localparam int          Div365Shift  = 27;
  localparam logic [63:0] Recip365     = ((64'd1 << 27) + 64'd364) / 64'd365;
  localparam int          Div153Shift  = 19;
  localparam logic [63:0] Recip153     = ((64'd1 << 19) + 64'd152) / 64'd153;

  // calendar constants
  localparam logic [18:0] EraOffset  = 19'd135080;  // 719468 mod 146097
  localparam logic [18:0] EraDays    = 19'd146097;
  localparam logic [17:0] EraLastDay = 18'd146096;
  localparam logic [18:0] WeekOffset = 19'd4;       // day zero was a thursday

  // reduced remainder handed from the modulus stages to the day split stages
  typedef struct packed {
    logic [RemW-1:0] rem;
    logic            missing;
  } red_t;

  // day within era and weekday handed to the civil date stages
  typedef struct packed {
    logic [DayW-1:0] doe;
    logic [2:0]      wd;
    logic            missing;
  } split_t;

  localparam logic [8:0] CumNorm [12] = '{9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
                                          9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334};
  localparam logic [8:0] CumLeap [12] = '{9'd0, 9'd31, 9'd60, 9'd91, 9'd121, 9'd152,
                                          9'd182, 9'd213, 9'd244, 9'd274, 9'd305, 9'd335};

  // first day of each march-based month, (153 * mp + 2) / 5
  function automatic logic [8:0] month_start(input logic [3:0] mp);
    logic [8:0] res;
    case (mp)
      4'd0:    res = 9'd0;
      4'd1:    res = 9'd31;
      4'd2:    res = 9'd61;
      4'd3:    res = 9'd92;
      4'd4:    res = 9'd122;
      4'd5:    res = 9'd153;
      4'd6:    res = 9'd184;
      4'd7:    res = 9'd214;
      4'd8:    res = 9'd245;
      4'd9:    res = 9'd275;
      4'd10:   res = 9'd306;
      4'd11:   res = 9'd337;
      default: res = 9'd0;
    endcase
    return res;
  endfunction

  // days before the month, january-based index
  function automatic logic [8:0] cum_days(input logic [3:0] idx, input logic leap);
    logic [8:0] res;
    res = 9'd0;
    if (idx < 4'd12) begin
      res = leap ? CumLeap[idx] : CumNorm[idx];
    end
    return res;
  endfunction

  // quarter from month 1 to 12
  function automatic logic [2:0] quarter_of(input logic [3:0] month);
    logic [2:0] res;
    case (month) inside
      [4'd1:4'd3]:   res = 3'd1;
      [4'd4:4'd6]:   res = 3'd2;
      [4'd7:4'd9]:   res = 3'd3;
      [4'd10:4'd12]: res = 3'd4;
      default:       res = 3'd0;
    endcase
    return res;
  endfunction

endpackage

@@ rtl/uxtd_mod_reduce.sv @@
// five-stage reduction of the day-shifted timestamp modulo 675 * 146097
module uxtd_mod_reduce (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  uxtd_pkg::in_t    item_i,
  output logic             valid_o,
  output uxtd_pkg::red_t   red_o
);

  logic signed [63:0] shifted;
  logic [8:0]         top_biased;

  logic        s1_valid_q, s2_valid_q, s3_valid_q, s4_valid_q, s5_valid_q;
  logic        s1_miss_q, s2_miss_q, s3_miss_q, s4_miss_q;
  logic [31:0] s1_lo_d, s1_lo_q;
  logic [42:0] s1_mid_d, s1_mid_q;
  logic [35:0] s1_top_d, s1_top_q;

  logic [uxtd_pkg::SumW-1:0] s2_sum_d, s2_sum_q;

  logic [50:0]               s3_prod;
  logic [uxtd_pkg::QuoW-1:0] s3_quo_d, s3_quo_q;
  logic [uxtd_pkg::RedW-1:0] s3_low_q;

  logic [45:0]               s4_qm;
  logic [uxtd_pkg::RedW-1:0] s4_rem_d, s4_rem_q;

  logic [uxtd_pkg::RedW-1:0] s5_r1;
  logic [uxtd_pkg::RedW-1:0] s5_r2;
  uxtd_pkg::red_t            s5_d, s5_q;

  // floor by 128, then split into chunks with constant weights modulo ModM
  assign shifted    = item_i.timestamp_seconds >>> uxtd_pkg::DayShift;
  assign top_biased = {~shifted[56], shifted[55:48]};
  assign s1_lo_d    = shifted[31:0];
  assign s1_mid_d   = shifted[47:32] * uxtd_pkg::Pow32Mod[uxtd_pkg::RemW-1:0];
  assign s1_top_d   = top_biased * uxtd_pkg::Pow48Mod[uxtd_pkg::RemW-1:0];

  // sum of weighted chunks plus the bias correction
  assign s2_sum_d = uxtd_pkg::SumW'(s1_lo_q) + uxtd_pkg::SumW'(s1_mid_q)
                  + uxtd_pkg::SumW'(s1_top_q) + uxtd_pkg::TopBias[uxtd_pkg::SumW-1:0];

  // quotient estimate by reciprocal, never above the true quotient
  assign s3_prod  = s2_sum_q[uxtd_pkg::SumW-1:uxtd_pkg::QuoPreShift] * uxtd_pkg::RecipM[25:0];
  assign s3_quo_d = s3_prod[50:uxtd_pkg::QuoPostShift];

  // remainder is below twice ModM, so low bits suffice
  assign s4_qm    = s3_quo_q * uxtd_pkg::ModM[uxtd_pkg::RemW-1:0];
  assign s4_rem_d = s3_low_q - s4_qm[uxtd_pkg::RedW-1:0];

  // final correction subtracts
  always_comb begin
    s5_r1 = s4_rem_q;
    if (s5_r1 >= uxtd_pkg::ModM[uxtd_pkg::RedW-1:0]) begin
      s5_r1 = s5_r1 - uxtd_pkg::ModM[uxtd_pkg::RedW-1:0];
    end
    s5_r2 = s5_r1;
    if (s5_r2 >= uxtd_pkg::ModM[uxtd_pkg::RedW-1:0]) begin
      s5_r2 = s5_r2 - uxtd_pkg::ModM[uxtd_pkg::RedW-1:0];
    end
    s5_d.rem     = s5_r2[uxtd_pkg::RemW-1:0];
    s5_d.missing = s4_miss_q;
  end

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
      s4_valid_q <= 1'b0;
      s5_valid_q <= 1'b0;
    end else if (en_i) begin
      s1_valid_q <= valid_i;
      s2_valid_q <= s1_valid_q;
      s3_valid_q <= s2_valid_q;
      s4_valid_q <= s3_valid_q;
      s5_valid_q <= s4_valid_q;
    end
  end

  // stage payload
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_lo_q   <= s1_lo_d;
      s1_mid_q  <= s1_mid_d;
      s1_top_q  <= s1_top_d;
      s1_miss_q <= item_i.missing_in;
      s2_sum_q  <= s2_sum_d;
      s2_miss_q <= s1_miss_q;
      s3_quo_q  <= s3_quo_d;
      s3_low_q  <= s2_sum_q[uxtd_pkg::RedW-1:0];
      s3_miss_q <= s2_miss_q;
      s4_rem_q  <= s4_rem_d;
      s4_miss_q <= s3_miss_q;
      s5_q      <= s5_d;
    end
  end

  assign valid_o = s5_valid_q;
  assign red_o   = s5_q;

endmodule

@@ rtl/uxtd_day_split.sv @@
// three stages: day within era, era offset and weekday
module uxtd_day_split (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  uxtd_pkg::red_t    red_i,
  output logic              valid_o,
  output uxtd_pkg::split_t  split_o
);

  logic s6_valid_q, s7_valid_q, s8_valid_q;
  logic s6_miss_q, s7_miss_q;

  logic [54:0]               s6_prod;
  logic [uxtd_pkg::DayW-1:0] s6_day_d, s6_day_q;

  logic [18:0]               s7_shift;
  logic [uxtd_pkg::DayW-1:0] s7_doe_d, s7_doe_q;
  logic [18:0]               s7_wk_d, s7_wk_q;
  logic [38:0]               s7_prod;
  logic [16:0]               s7_q7_d, s7_q7_q;

  uxtd_pkg::split_t s8_d, s8_q;

  // day within era from the reduced remainder, divide by 675
  assign s6_prod  = red_i.rem * uxtd_pkg::RecipSec[27:0];
  assign s6_day_d = s6_prod[54:uxtd_pkg::DivSecShift];

  // move to the march-based era and prepare the weekday divide
  assign s7_shift = {1'b0, s6_day_q} + uxtd_pkg::EraOffset;
  assign s7_doe_d = (s7_shift >= uxtd_pkg::EraDays)
                  ? uxtd_pkg::DayW'(s7_shift - uxtd_pkg::EraDays)
                  : s7_shift[uxtd_pkg::DayW-1:0];
  assign s7_wk_d  = {1'b0, s6_day_q} + uxtd_pkg::WeekOffset;
  assign s7_prod  = s7_wk_d * uxtd_pkg::Recip7[19:0];
  assign s7_q7_d  = s7_prod[38:uxtd_pkg::Div7Shift];

  // weekday: x - 7q equals x + q in the low three bits
  always_comb begin
    s8_d.doe     = s7_doe_q;
    s8_d.wd      = s7_wk_q[2:0] + s7_q7_q[2:0];
    s8_d.missing = s7_miss_q;
  end

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s6_valid_q <= 1'b0;
      s7_valid_q <= 1'b0;
      s8_valid_q <= 1'b0;
    end else if (en_i) begin
      s6_valid_q <= valid_i;
      s7_valid_q <= s6_valid_q;
      s8_valid_q <= s7_valid_q;
    end
  end

  // stage payload
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s6_day_q  <= s6_day_d;
      s6_miss_q <= red_i.missing;
      s7_doe_q  <= s7_doe_d;
      s7_wk_q   <= s7_wk_d;
      s7_q7_q   <= s7_q7_d;
      s7_miss_q <= s6_miss_q;
      s8_q      <= s8_d;
    end
  end

  assign valid_o = s8_valid_q;
  assign split_o = s8_q;

endmodule

@@ rtl/uxtd_civil.sv @@
// five stages: era corrections, year of era, day of year, month and the output register
module uxtd_civil (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  uxtd_pkg::split_t  split_i,
  output logic              valid_o,
  output uxtd_pkg::out_t    data_o
);

  logic ca_valid_q, cb_valid_q, cc_valid_q, cd_valid_q, ce_valid_q;
  logic ca_miss_q, cb_miss_q, cc_miss_q, cd_miss_q;
  logic [2:0] ca_wd_q, cb_wd_q, cc_wd_q, cd_wd_q;

  // stage a
  logic [36:0]               ca_p1460, ca_p36524;
  logic [7:0]                ca_n1460;
  logic [2:0]                ca_n36524;
  logic                      ca_last;
  logic [uxtd_pkg::DayW-1:0] ca_t_d, ca_t_q, ca_doe_q;

  // stage b
  logic [36:0]               cb_prod;
  logic [8:0]                cb_yoe_d, cb_yoe_q;
  logic [uxtd_pkg::DayW-1:0] cb_doe_q;

  // stage c
  logic [1:0]                cc_cent;
  logic [uxtd_pkg::DayW-1:0] cc_base;
  logic [uxtd_pkg::DayW-1:0] cc_diff;
  logic [8:0]                cc_doy_d, cc_doy_q, cc_yoe_q;

  // stage d
  logic [10:0] cd_num;
  logic [22:0] cd_prod;
  logic [3:0]  cd_mp_d, cd_mp_q;
  logic [8:0]  cd_doy_q, cd_yoe_q;

  // stage e
  logic [8:0]     ce_dom;
  logic [3:0]     ce_month;
  logic [8:0]     ce_ylocal;
  logic           ce_leap;
  uxtd_pkg::out_t ce_d, ce_q;

  // four-year, century and four-century corrections to the day of era
  assign ca_p1460  = split_i.doe * uxtd_pkg::Recip1460[18:0];
  assign ca_n1460  = ca_p1460[36:uxtd_pkg::Div1460Shift];
  assign ca_p36524 = split_i.doe * uxtd_pkg::Recip36524[18:0];
  assign ca_n36524 = ca_p36524[36:uxtd_pkg::Div36524Shift];
  assign ca_last   = (split_i.doe == uxtd_pkg::EraLastDay);
  assign ca_t_d    = split_i.doe - uxtd_pkg::DayW'(ca_n1460)
                   + uxtd_pkg::DayW'(ca_n36524) - uxtd_pkg::DayW'(ca_last);

  // year of era, divide by 365
  assign cb_prod  = ca_t_q * uxtd_pkg::Recip365[18:0];
  assign cb_yoe_d = cb_prod[35:uxtd_pkg::Div365Shift];

  // day of the march-based year
  always_comb begin
    if (cb_yoe_q >= 9'd300) begin
      cc_cent = 2'd3;
    end else if (cb_yoe_q >= 9'd200) begin
      cc_cent = 2'd2;
    end else if (cb_yoe_q >= 9'd100) begin
      cc_cent = 2'd1;
    end else begin
      cc_cent = 2'd0;
    end
    cc_base  = uxtd_pkg::DayW'(cb_yoe_q) * 18'd365 + uxtd_pkg::DayW'(cb_yoe_q[8:2])
             - uxtd_pkg::DayW'(cc_cent);
    cc_diff  = cb_doe_q - cc_base;
    cc_doy_d = cc_diff[8:0];
  end

  // march-based month, (5 * doy + 2) / 153
  assign cd_num  = 11'(cc_doy_q) * 11'd5 + 11'd2;
  assign cd_prod = cd_num * uxtd_pkg::Recip153[11:0];
  assign cd_mp_d = cd_prod[22:uxtd_pkg::Div153Shift];

  // calendar month, leap test within the era, output fields
  always_comb begin
    ce_dom    = cd_doy_q - uxtd_pkg::month_start(cd_mp_q) + 9'd1;
    ce_month  = (cd_mp_q < 4'd10) ? cd_mp_q + 4'd3 : cd_mp_q - 4'd9;
    ce_ylocal = cd_yoe_q + 9'((ce_month <= 4'd2) ? 1'b1 : 1'b0);
    ce_leap   = (ce_ylocal[1:0] == 2'd0) && (ce_ylocal != 9'd100)
             && (ce_ylocal != 9'd200) && (ce_ylocal != 9'd300);
    ce_d      = '0;
    if (cd_miss_q) begin
      ce_d.missing_out = 1'b1;
    end else begin
      ce_d.day_of_week    = cd_wd_q;
      ce_d.month_number   = ce_month;
      ce_d.day_of_year    = uxtd_pkg::cum_days(ce_month - 4'd1, ce_leap) + ce_dom;
      ce_d.quarter_number = uxtd_pkg::quarter_of(ce_month);
      ce_d.is_weekend     = (cd_wd_q == 3'd0) || (cd_wd_q == 3'd6);
    end
  end

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ca_valid_q <= 1'b0;
      cb_valid_q <= 1'b0;
      cc_valid_q <= 1'b0;
      cd_valid_q <= 1'b0;
      ce_valid_q <= 1'b0;
    end else if (en_i) begin
      ca_valid_q <= valid_i;
      cb_valid_q <= ca_valid_q;
      cc_valid_q <= cb_valid_q;
      cd_valid_q <= cc_valid_q;
      ce_valid_q <= cd_valid_q;
    end
  end

  // stage payload
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ca_t_q    <= ca_t_d;
      ca_doe_q  <= split_i.doe;
      ca_wd_q   <= split_i.wd;
      ca_miss_q <= split_i.missing;
      cb_yoe_q  <= cb_yoe_d;
      cb_doe_q  <= ca_doe_q;
      cb_wd_q   <= ca_wd_q;
      cb_miss_q <= ca_miss_q;
      cc_doy_q  <= cc_doy_d;
      cc_yoe_q  <= cb_yoe_q;
      cc_wd_q   <= cb_wd_q;
      cc_miss_q <= cb_miss_q;
      cd_mp_q   <= cd_mp_d;
      cd_doy_q  <= cc_doy_q;
      cd_yoe_q  <= cc_yoe_q;
      cd_wd_q   <= cc_wd_q;
      cd_miss_q <= cc_miss_q;
      ce_q      <= ce_d;
    end
  end

  assign valid_o = ce_valid_q;
  assign data_o  = ce_q;

endmodule

@@ rtl/unix_time_date_features_core.sv @@
// top level of the unix time date feature pipeline
// Turns a signed 64-bit unix timestamp in seconds into weekday (0 is sunday), month,
// day of year, quarter and a weekend flag of the proleptic gregorian date; a missing
// input gives missing_out set and all other fields zero. The pipeline takes one
// transfer every clock while it is not stalled: five stages reduce the timestamp modulo
// 675 * 146097 days-and-seconds with constant multipliers, three derive the day within
// the 400-year era and the weekday, and five work out the civil date, the last being
// the output register. When the output register holds a result that is not taken,
// the whole pipeline stalls and in_ready_o drops in the same cycle; nothing is lost
// or repeated. No state survives between items.
module unix_time_date_features_core (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  uxtd_pkg::in_t   in_data_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output uxtd_pkg::out_t  out_data_o
);

  logic             advance;
  logic             red_valid;
  uxtd_pkg::red_t   red;
  logic             split_valid;
  uxtd_pkg::split_t split;

  // the pipeline moves whenever the output register is free or being taken
  assign advance    = !out_valid_o || out_ready_i;
  assign in_ready_o = advance;

  uxtd_mod_reduce u_reduce (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (advance),
    .valid_i (in_valid_i),
    .item_i  (in_data_i),
    .valid_o (red_valid),
    .red_o   (red)
  );

  uxtd_day_split u_split (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (advance),
    .valid_i (red_valid),
    .red_i   (red),
    .valid_o (split_valid),
    .split_o (split)
  );

  uxtd_civil u_civil (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (advance),
    .valid_i (split_valid),
    .split_i (split),
    .valid_o (out_valid_o),
    .data_o  (out_data_o)
  );

endmodule

@@ tb/testbench.sv @@
// self-checking testbench for the unix time date feature pipeline
`timescale 1ns / 1ps

module testbench;

  // seconds in a day, days from 0000-03-01 to 1970-01-01, days in a 400-year era
  localparam longint SecsPerDay = 86400;
  localparam longint EpochShift = 719468;
  localparam longint EraLen     = 146097;
  localparam int     CycleLimit = 400000;
  localparam int     DrainCycles = 40;

  // days before each month, january first
  localparam int unsigned DaysBeforeNorm [12] = '{0, 31, 59, 90, 120, 151,
                                                  181, 212, 243, 273, 304, 334};
  localparam int unsigned DaysBeforeLeap [12] = '{0, 31, 60, 91, 121, 152,
                                                  182, 213, 244, 274, 305, 335};

  logic            clk_i;
  logic            rst_ni;
  logic            in_valid_i;
  logic            in_ready_o;
  uxtd_pkg::in_t   in_data_i;
  logic            out_valid_o;
  logic            out_ready_i;
  uxtd_pkg::out_t  out_data_o;

  uxtd_pkg::in_t   ts_items [$];
  uxtd_pkg::out_t  expected_features [$];
  uxtd_pkg::out_t  want;
  bit              in_taken;
  int              send_gap;
  int              stall_left;
  bit              send_calm;
  bit              recv_calm;
  int              sent_count;
  int              recv_count;
  int              cycle_count;
  int              mismatch_count;

  unix_time_date_features_core DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  // 8 ns clock
  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  // calendar features of one timestamp, floor division on days and eras
  function automatic uxtd_pkg::out_t civil_features(input uxtd_pkg::in_t item);
    longint          ts, days, z, era, wd;
    int unsigned     doe, yoe, doy, mp, dom, mon, ylocal, days_prior;
    bit              leap;
    uxtd_pkg::out_t  res;
    res = '0;
    if (item.missing_in) begin
      res.missing_out = 1'b1;
      return res;
    end
    ts = item.timestamp_seconds;
    days = ts / SecsPerDay;
    if (ts % SecsPerDay < 0) days--;
    wd = (days + 4) % 7;
    if (wd < 0) wd += 7;
    z = days + EpochShift;
    era = z / EraLen;
    if (z % EraLen < 0) era--;
    doe = int'(z - era * EraLen);
    yoe = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
    doy = doe - (365 * yoe + yoe / 4 - yoe / 100);
    mp = (5 * doy + 2) / 153;
    dom = doy - (153 * mp + 2) / 5 + 1;
    mon = (mp < 10) ? mp + 3 : mp - 9;
    ylocal = yoe + ((mon <= 2) ? 1 : 0);
    leap = ((ylocal % 4 == 0) && (ylocal % 100 != 0)) || (ylocal % 400 == 0);
    days_prior = leap ? DaysBeforeLeap[mon - 1] : DaysBeforeNorm[mon - 1];
    res.day_of_week    = wd[2:0];
    res.month_number   = mon[3:0];
    res.day_of_year    = 9'(days_prior + dom);
    res.quarter_number = 3'((mon - 1) / 3 + 1);
    res.is_weekend     = (wd == 0) || (wd == 6);
    res.missing_out    = 1'b0;
    return res;
  endfunction

  // idle length: mostly none or short, now and then long, none in calm stretches
  function automatic int idle_length(input bit calm);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // random timestamp: full range, near the present eras, day edges, or scaled down
  function automatic uxtd_pkg::in_t random_item();
    uxtd_pkg::in_t item;
    int unsigned   kind;
    longint        dayno;
    longint        raw;
    kind = $urandom_range(0, 99);
    item.missing_in = ($urandom_range(0, 9) == 0);
    dayno = longint'($urandom_range(0, 2000000)) - 1000000;
    raw = {$urandom, $urandom};
    if (kind < 30) begin
      item.timestamp_seconds = raw;
    end else if (kind < 70) begin
      item.timestamp_seconds = dayno * SecsPerDay + longint'($urandom_range(0, 86399));
    end else if (kind < 85) begin
      item.timestamp_seconds = dayno * SecsPerDay + longint'($urandom_range(0, 2)) - 1;
    end else begin
      item.timestamp_seconds = raw >>> $urandom_range(1, 62);
    end
    return item;
  endfunction

  // handshake sampling and result checking on the rising edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      cycle_count++;
      if (in_valid_i && in_ready_o) begin
        expected_features.insert(expected_features.size(), civil_features(in_data_i));
        in_taken = 1'b1;
      end
      if (out_valid_o && out_ready_i) begin
        if (expected_features.size() == 0) begin
          $error("unexpected result transfer");
          mismatch_count++;
        end else begin
          want = expected_features.pop_front();
          if (out_data_o.day_of_week !== want.day_of_week) begin
            $error("day_of_week expected %0d got %0d", want.day_of_week,
                   out_data_o.day_of_week);
            mismatch_count++;
          end
          if (out_data_o.month_number !== want.month_number) begin
            $error("month_number expected %0d got %0d", want.month_number,
                   out_data_o.month_number);
            mismatch_count++;
          end
          if (out_data_o.day_of_year !== want.day_of_year) begin
            $error("day_of_year expected %0d got %0d", want.day_of_year,
                   out_data_o.day_of_year);
            mismatch_count++;
          end
          if (out_data_o.quarter_number !== want.quarter_number) begin
            $error("quarter_number expected %0d got %0d", want.quarter_number,
                   out_data_o.quarter_number);
            mismatch_count++;
          end
          if (out_data_o.is_weekend !== want.is_weekend) begin
            $error("is_weekend expected %0d got %0d", want.is_weekend,
                   out_data_o.is_weekend);
            mismatch_count++;
          end
          if (out_data_o.missing_out !== want.missing_out) begin
            $error("missing_out expected %0d got %0d", want.missing_out,
                   out_data_o.missing_out);
            mismatch_count++;
          end
        end
      end
    end
  end

  // input driver: next timestamp once the current transfer is done, with random gaps
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || in_taken) begin
      in_taken = 1'b0;
      if (send_gap > 0) begin
        in_valid_i <= 1'b0;
        send_gap--;
      end else if (ts_items.size() != 0) begin
        in_data_i  <= ts_items.pop_front();
        in_valid_i <= 1'b1;
        sent_count++;
        if (sent_count % 50 == 0) send_calm = ($urandom_range(0, 3) == 0);
        send_gap = idle_length(send_calm);
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // result side backpressure
  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      out_ready_i <= 1'b0;
      stall_left--;
    end else begin
      out_ready_i <= 1'b1;
      recv_count++;
      if (recv_count % 60 == 0) recv_calm = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 4) == 0) stall_left = idle_length(recv_calm);
    end
  end

  // watchdog
  initial begin
    wait (cycle_count >= CycleLimit);
    $display("unix_time_date_features_core: mismatch");
    $finish;
  end

  // stimulus and end of run
  initial begin
    uxtd_pkg::in_t item;
    longint        corner_ts [19] = '{
      64'sd0, -64'sd1, 64'sd86399, 64'sd86400, -64'sd86400, -64'sd86401,
      64'sh7fff_ffff_ffff_ffff, 64'sh8000_0000_0000_0000,
      64'sd951782400,      // 2000-02-29, leap day of a century leap year
      64'sd951868800,      // 2000-03-01, first day of an era
      64'sd978220800,      // 2000-12-31, day 366
      -64'sd2203891200,    // 1900-03-01, century year that is not leap
      64'sd4107456000,     // 2100-02-28
      64'sd1735603200,     // 2024-12-31
      -64'sd62162035200,   // 0000-03-01
      -64'sd62162035201,   // last second of 0000-02-29
      64'sd1704067200,     // 2024-01-01, a monday
      64'sd1704499200,     // saturday
      64'sd1704585600      // sunday
    };
    longint        absent_ts [3] = '{64'sd0, 64'sh7fff_ffff_ffff_ffff,
                                     64'sh8000_0000_0000_0000};

    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    in_data_i      = '0;
    out_ready_i    = 1'b0;
    in_taken       = 1'b0;
    send_gap       = 0;
    stall_left     = 0;
    send_calm      = 1'b0;
    recv_calm      = 1'b0;
    sent_count     = 0;
    recv_count     = 0;
    cycle_count    = 0;
    mismatch_count = 0;

    // directed corners, then missing rows, then random mix
    foreach (corner_ts[i]) begin
      item.timestamp_seconds = corner_ts[i];
      item.missing_in = 1'b0;
      ts_items.insert(ts_items.size(), item);
    end
    foreach (absent_ts[i]) begin
      item.timestamp_seconds = absent_ts[i];
      item.missing_in = 1'b1;
      ts_items.insert(ts_items.size(), item);
    end
    repeat (850) ts_items.insert(ts_items.size(), random_item());

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (ts_items.size() != 0 || in_valid_i) @(negedge clk_i);
    while (expected_features.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);

    if (mismatch_count == 0) begin
      $display("unix_time_date_features_core: match");
    end else begin
      $display("unix_time_date_features_core: mismatch");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/uxtd_pkg.sv
rtl/uxtd_mod_reduce.sv
rtl/uxtd_day_split.sv
rtl/uxtd_civil.sv
rtl/unix_time_date_features_core.sv
tb/testbench.sv
